FILE: hdl/a2pi_pkg.sv
// Shared constants, types and the arctangent table of the angle pipeline.
`timescale 1ns / 1ps
package a2pi_pkg;

   localparam int COORD_BITS_DEF = 16;
   localparam int ITERATIONS_DEF = 16;

   // Datapath widths are fixed by the number format, not by the coordinates.
   localparam int DATA_BITS  = 64;
   localparam int ACC_BITS   = 32;
   localparam int ANGLE_BITS = 17;
   localparam int SHIFT_BITS = 6;
   localparam int NORM_TOP   = 60;
   localparam int TABLE_SIZE = 32;

   // Angle codes, 32768 is one half turn.
   localparam logic signed [ANGLE_BITS-1:0] ANGLE_ZERO      = 17'sd0;
   localparam logic signed [ANGLE_BITS-1:0] ANGLE_QUARTER   = 17'sd16384;
   localparam logic signed [ANGLE_BITS-1:0] ANGLE_NEG_QUART = -17'sd16384;
   localparam logic signed [ANGLE_BITS-1:0] ANGLE_HALF      = 17'sd32768;
   localparam logic signed [ANGLE_BITS-1:0] ANGLE_NEG_HALF  = -17'sd32768;

   // Accumulator limits and rounding, in units of 2^-30 of a half turn.
   localparam logic signed [ACC_BITS-1:0] ACC_MAX   = 32'sd536870912;
   localparam logic signed [ACC_BITS-1:0] ACC_ROUND = 32'sd16384;

   // round(atan(2^-i) / pi * 2^30)
   localparam logic [ACC_BITS-1:0] ATAN_TABLE [TABLE_SIZE] = '{
      32'd268435456, 32'd158466703, 32'd83729454, 32'd42502378,
      32'd21333666,  32'd10677233,  32'd5339919,  32'd2670123,
      32'd1335082,   32'd667543,    32'd333772,   32'd166886,
      32'd83443,     32'd41722,     32'd20861,    32'd10430,
      32'd5215,      32'd2608,      32'd1304,     32'd652,
      32'd326,       32'd163,       32'd81,       32'd41,
      32'd20,        32'd10,        32'd5,        32'd3,
      32'd1,         32'd1,         32'd0,        32'd0
   };

   typedef struct packed {
      logic origin;
      logic x_zero;
      logic y_zero;
      logic x_neg;
      logic y_neg;
   } ctrl_type;

   typedef struct packed {
      ctrl_type                     ctrl;
      logic signed [DATA_BITS-1:0]  x;
      logic signed [DATA_BITS-1:0]  y;
      logic signed [ACC_BITS-1:0]   acc;
   } cordic_type;

endpackage

FILE: hdl/a2pi_req_if.sv
// Request channel: a coordinate pair with valid/ready handshake.
`timescale 1ns / 1ps
interface a2pi_req_if #(
   parameter int COORD_BITS = a2pi_pkg::COORD_BITS_DEF
);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] coord_y;
   logic signed [COORD_BITS-1:0] coord_x;

   modport source (output valid, output coord_y, output coord_x, input ready);
   modport sink   (input valid, input coord_y, input coord_x, output ready);
endinterface

FILE: hdl/a2pi_rsp_if.sv
// Response channel: one angle with valid/ready handshake.
`timescale 1ns / 1ps
interface a2pi_rsp_if;
   import a2pi_pkg::*;

   logic                         valid;
   logic                         ready;
   logic signed [ANGLE_BITS-1:0] angle;

   modport source (output valid, output angle, input ready);
   modport sink   (input valid, input angle, output ready);
endinterface

FILE: hdl/a2pi_front.sv
// Front end: fold onto the first quadrant and normalize the magnitudes.
`timescale 1ns / 1ps
module a2pi_front #(
   parameter int COORD_BITS = a2pi_pkg::COORD_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   a2pi_req_if.sink               req_bus,
   output a2pi_pkg::cordic_type   dn_data,
   output logic                   dn_valid,
   input  logic                   dn_ready
);
   import a2pi_pkg::*;

   // stage 1: magnitudes and quadrant
   logic                  v1_ff;
   ctrl_type              ctrl1_ff, ctrl1_in;
   logic [COORD_BITS-1:0] ax1_ff, ax1_in, ay1_ff, ay1_in;
   // stage 2: leading-one position
   logic                  v2_ff;
   ctrl_type              ctrl2_ff;
   logic [COORD_BITS-1:0] ax2_ff, ay2_ff;
   logic [SHIFT_BITS-1:0] sh2_ff, sh2_in;
   // stage 3: normalized vector
   logic                  v3_ff;
   cordic_type            d3_ff, d3_in;

   logic                  r1, r2, r3;
   logic [COORD_BITS-1:0] big;
   logic [SHIFT_BITS-1:0] top;

   assign r3 = ~v3_ff | dn_ready;
   assign r2 = ~v2_ff | r3;
   assign r1 = ~v1_ff | r2;
   assign req_bus.ready = r1;

   always_comb begin
      ctrl1_in.x_neg  = req_bus.coord_x[COORD_BITS-1];
      ctrl1_in.y_neg  = req_bus.coord_y[COORD_BITS-1];
      ctrl1_in.x_zero = (req_bus.coord_x == '0);
      ctrl1_in.y_zero = (req_bus.coord_y == '0);
      ctrl1_in.origin = ctrl1_in.x_zero & ctrl1_in.y_zero;
      ax1_in = ctrl1_in.x_neg ? (~req_bus.coord_x + 1'b1) : req_bus.coord_x;
      ay1_in = ctrl1_in.y_neg ? (~req_bus.coord_y + 1'b1) : req_bus.coord_y;
   end

   always_comb begin
      big = (ax1_ff > ay1_ff) ? ax1_ff : ay1_ff;
      top = '0;
      for (int i = 0; i < COORD_BITS; i++) begin
         if (big[i]) begin
            top = SHIFT_BITS'(i);
         end
      end
      sh2_in = SHIFT_BITS'(NORM_TOP) - top;
   end

   always_comb begin
      d3_in.ctrl = ctrl2_ff;
      d3_in.x    = $signed(DATA_BITS'(ax2_ff) << sh2_ff);
      d3_in.y    = $signed(DATA_BITS'(ay2_ff) << sh2_ff);
      d3_in.acc  = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (r1) v1_ff <= req_bus.valid;
         if (r2) v2_ff <= v1_ff;
         if (r3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (r1 && req_bus.valid) begin
         ctrl1_ff <= ctrl1_in;
         ax1_ff   <= ax1_in;
         ay1_ff   <= ay1_in;
      end
      if (r2 && v1_ff) begin
         ctrl2_ff <= ctrl1_ff;
         ax2_ff   <= ax1_ff;
         ay2_ff   <= ay1_ff;
         sh2_ff   <= sh2_in;
      end
      if (r3 && v2_ff) begin
         d3_ff <= d3_in;
      end
   end

   assign dn_data  = d3_ff;
   assign dn_valid = v3_ff;

endmodule

FILE: hdl/a2pi_cell.sv
// One vectoring CORDIC micro-rotation with its pipeline register.
`timescale 1ns / 1ps
module a2pi_cell #(
   parameter int STAGE = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  a2pi_pkg::cordic_type   up_data,
   input  logic                   up_valid,
   output logic                   up_ready,
   output a2pi_pkg::cordic_type   dn_data,
   output logic                   dn_valid,
   input  logic                   dn_ready
);
   import a2pi_pkg::*;

   logic                        valid_ff;
   cordic_type                  data_ff, data_in;
   logic signed [DATA_BITS-1:0] x_cur, y_cur, dx, dy;
   logic signed [ACC_BITS-1:0]  step;

   assign up_ready = ~valid_ff | dn_ready;

   always_comb begin
      x_cur = up_data.x;
      y_cur = up_data.y;
      // arithmetic shift rounds toward minus infinity
      dx    = y_cur >>> STAGE;
      dy    = x_cur >>> STAGE;
      step  = $signed(ATAN_TABLE[STAGE]);
      data_in.ctrl = up_data.ctrl;
      if (!y_cur[DATA_BITS-1]) begin
         data_in.x   = x_cur + dx;
         data_in.y   = y_cur - dy;
         data_in.acc = up_data.acc + step;
      end else begin
         data_in.x   = x_cur - dx;
         data_in.y   = y_cur + dy;
         data_in.acc = up_data.acc - step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign dn_data  = data_ff;
   assign dn_valid = valid_ff;

endmodule

FILE: hdl/a2pi_back.sv
// Back end: clamp and round the angle, unfold the quadrant, hold the response.
`timescale 1ns / 1ps
module a2pi_back (
   input  logic                   clock,
   input  logic                   reset,
   input  a2pi_pkg::cordic_type   up_data,
   input  logic                   up_valid,
   output logic                   up_ready,
   a2pi_rsp_if.source             rsp_bus
);
   import a2pi_pkg::*;

   logic                         valid_ff;
   logic signed [ANGLE_BITS-1:0] angle_ff, angle_in, quad;
   logic signed [ACC_BITS-1:0]   acc_c, acc_r;
   logic signed [ANGLE_BITS-1:0] t;

   assign up_ready = ~valid_ff | rsp_bus.ready;

   always_comb begin
      if (up_data.acc[ACC_BITS-1]) begin
         acc_c = '0;
      end else if (up_data.acc > ACC_MAX) begin
         acc_c = ACC_MAX;
      end else begin
         acc_c = up_data.acc;
      end
      acc_r = acc_c + ACC_ROUND;
      t     = $signed(ANGLE_BITS'(acc_r[29:15]));

      // unfold from the first quadrant
      if (!up_data.ctrl.x_neg && !up_data.ctrl.y_neg) begin
         quad = t;
      end else if (up_data.ctrl.x_neg && !up_data.ctrl.y_neg) begin
         quad = ANGLE_HALF - t;
      end else if (up_data.ctrl.x_neg) begin
         quad = t - ANGLE_HALF;
      end else begin
         quad = ANGLE_ZERO - t;
      end
      // minus one half turn is the same direction as plus one
      if (quad == ANGLE_NEG_HALF) begin
         quad = ANGLE_HALF;
      end

      if (up_data.ctrl.origin) begin
         angle_in = ANGLE_ZERO;
      end else if (up_data.ctrl.x_zero) begin
         angle_in = up_data.ctrl.y_neg ? ANGLE_NEG_QUART : ANGLE_QUARTER;
      end else if (up_data.ctrl.y_zero) begin
         angle_in = up_data.ctrl.x_neg ? ANGLE_HALF : ANGLE_ZERO;
      end else begin
         angle_in = quad;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         angle_ff <= angle_in;
      end
   end

   assign rsp_bus.valid = valid_ff;
   assign rsp_bus.angle = angle_ff;

endmodule

FILE: hdl/atan2_over_pi.sv
// Top level: pipelined atan2(y, x) / pi with a chain of CORDIC cells.
//
// Usage:
//   req_bus carries a signed pair (coord_y, coord_x); a request is taken at a
//   rising edge with valid and ready both high. rsp_bus returns one angle per
//   request, in order: atan2(y, x) / pi scaled so 32768 is one half turn,
//   rounded to nearest, in -32767..32768.
//   A request passes through three front stages (fold, leading-one search,
//   normalize shift), one cell per CORDIC iteration, and the output
//   register.
//   Throughput is one request per cycle while the receiver keeps up; each cell
//   does one 64-bit add/subtract pair and one accumulator step per cycle.
//   Every stage has its own valid bit and advances whenever the stage after
//   it is empty or moving, so bubbles collapse and requests keep entering
//   while a finished response waits. When the receiver stalls, the response
//   holds and the chain fills up; ready drops once every stage is occupied.
//   Reset clears every valid bit together; no clearing pass is needed.
`timescale 1ns / 1ps
module atan2_over_pi #(
   parameter int COORD_BITS = a2pi_pkg::COORD_BITS_DEF,
   parameter int ITERATIONS = a2pi_pkg::ITERATIONS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   a2pi_req_if.sink   req_bus,
   a2pi_rsp_if.source rsp_bus
);
   import a2pi_pkg::*;

   // link[k] feeds cell k; link[ITERATIONS] feeds the back end
   cordic_type link_data  [ITERATIONS+1];
   logic       link_valid [ITERATIONS+1];
   logic       link_ready [ITERATIONS+1];

   // fold and normalize
   a2pi_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .dn_data  (link_data[0]),
      .dn_valid (link_valid[0]),
      .dn_ready (link_ready[0])
   );

   // one micro-rotation per cell, data advances one cell per cycle unless stalled
   for (genvar k = 0; k < ITERATIONS; k++) begin : g_cell
      a2pi_cell #(
         .STAGE (k)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_data  (link_data[k]),
         .up_valid (link_valid[k]),
         .up_ready (link_ready[k]),
         .dn_data  (link_data[k+1]),
         .dn_valid (link_valid[k+1]),
         .dn_ready (link_ready[k+1])
      );
   end

   // round, unfold, hold the response
   a2pi_back u_back (
      .clock    (clock),
      .reset    (reset),
      .up_data  (link_data[ITERATIONS]),
      .up_valid (link_valid[ITERATIONS]),
      .up_ready (link_ready[ITERATIONS]),
      .rsp_bus  (rsp_bus)
   );

   // An empty output register lets the whole chain move, so requests flow.
   a_ready_when_empty : assert property (@(posedge clock) disable iff (reset)
      !rsp_bus.valid |-> req_bus.ready)
      else $error("request blocked while the response register is empty");

   // A result leaving the last cell must show up as a response.
   a_last_cell_to_rsp : assert property (@(posedge clock) disable iff (reset)
      (link_valid[ITERATIONS] && link_ready[ITERATIONS]) |=> rsp_bus.valid)
      else $error("result from the last cell was dropped");

   // Angle stays in (-1, 1]: at most 32768, never minus one half turn.
   a_angle_range : assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |->
         ((!rsp_bus.angle[16] && (rsp_bus.angle[15:0] <= 16'h8000)) ||
          (rsp_bus.angle[16] && rsp_bus.angle[15] && (rsp_bus.angle[14:0] != 15'h0))))
      else $error("angle out of range");

endmodule
